@@ sv/vec3_normalize_unit_defines.svh @@
// assertion macros shared by the vector normalize rtl
// no dependencies; expects clock and reset in the including module
`ifndef VEC3_NORMALIZE_UNIT_DEFINES_SVH
`define VEC3_NORMALIZE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VNORM_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vnorm assertion failed");

// next-cycle implication, checked outside reset
`define VNORM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vnorm assertion failed");

`endif

@@ sv/vnorm_pkg.sv @@
// shared widths, stage counts and the side-band struct of the normalize pipeline
// no dependencies; imported by every vnorm module
package vnorm_pkg;

   localparam int COMP_W      = 24;
   localparam int MAG_W       = 24;
   localparam int SQ_W        = 47;
   localparam int SUM_W       = 48;
   localparam int ROOT_W      = 24;
   localparam int REM_W       = ROOT_W + 1;
   localparam int ACC_W       = REM_W + 2;
   localparam int QUO_W       = 17;
   localparam int OUT_W       = 18;
   localparam int NCOMP       = 3;
   localparam int SQRT_STAGES = SUM_W / 2;
   localparam int DIV_STAGES  = QUO_W;
   localparam int NSTAGES     = 3 + SQRT_STAGES + DIV_STAGES + 1;
   localparam int IN_DATA_W   = 72;
   localparam int OUT_DATA_W  = 56;

   localparam logic [QUO_W-1:0] UNIT = QUO_W'(65536);

   typedef struct packed {
      logic [NCOMP-1:0][MAG_W-1:0] mag;
      logic [NCOMP-1:0]            neg;
      logic                        fail;
   } side_type;

endpackage

@@ sv/vnorm_sqrt.sv @@
// pipelined floor square root, two radicand bits resolved per stage
// depends on vnorm_pkg; carries the side-band struct alongside the data
module vnorm_sqrt import vnorm_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [SUM_W-1:0]  sum_in,
   input  side_type          side_in,
   output logic [ROOT_W-1:0] root_out,
   output side_type          side_out
);

   logic [REM_W-1:0]  rem_ff   [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff  [SQRT_STAGES];
   logic [SUM_W-1:0]  rad_ff   [SQRT_STAGES];
   side_type          side_ff  [SQRT_STAGES];

   logic [REM_W-1:0]  rem_in   [SQRT_STAGES];
   logic [ROOT_W-1:0] root_in  [SQRT_STAGES];
   logic [SUM_W-1:0]  rad_in   [SQRT_STAGES];

   logic [REM_W-1:0]  prv_rem  [SQRT_STAGES];
   logic [ROOT_W-1:0] prv_root [SQRT_STAGES];
   logic [SUM_W-1:0]  prv_rad  [SQRT_STAGES];
   logic [ACC_W-1:0]  acc      [SQRT_STAGES];
   logic [ACC_W-1:0]  trial    [SQRT_STAGES];
   logic              ge       [SQRT_STAGES];

   always_comb begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            prv_rem[k]  = '0;
            prv_root[k] = '0;
            prv_rad[k]  = sum_in;
         end else begin
            prv_rem[k]  = rem_ff[k-1];
            prv_root[k] = root_ff[k-1];
            prv_rad[k]  = rad_ff[k-1];
         end
         acc[k]     = {prv_rem[k], prv_rad[k][SUM_W-1 -: 2]};
         trial[k]   = {1'b0, prv_root[k], 2'b01};
         ge[k]      = (acc[k] >= trial[k]);
         rem_in[k]  = ge[k] ? REM_W'(acc[k] - trial[k]) : REM_W'(acc[k]);
         root_in[k] = {prv_root[k][ROOT_W-2:0], ge[k]};
         rad_in[k]  = {prv_rad[k][SUM_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= (k == 0) ? side_in : side_ff[k-1];
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES-1];
   assign side_out = side_ff[SQRT_STAGES-1];

endmodule

@@ sv/vnorm_div.sv @@
// pipelined restoring divider, (mag * 65536) / length for three components
// depends on vnorm_pkg; one quotient bit per stage, side-band travels along
module vnorm_div import vnorm_pkg::*; (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [ROOT_W-1:0]           len_in,
   input  side_type                    side_in,
   output logic [NCOMP-1:0][QUO_W-1:0] quo_out,
   output side_type                    side_out
);

   logic [ROOT_W-1:0] rem_ff  [DIV_STAGES][NCOMP];
   logic [QUO_W-1:0]  quo_ff  [DIV_STAGES][NCOMP];
   logic [ROOT_W-1:0] len_ff  [DIV_STAGES];
   side_type          side_ff [DIV_STAGES];

   logic [ROOT_W-1:0] rem_in  [DIV_STAGES][NCOMP];
   logic [QUO_W-1:0]  quo_in  [DIV_STAGES][NCOMP];
   logic [ROOT_W-1:0] prv_len [DIV_STAGES];
   logic [ROOT_W-1:0] prv_rem [DIV_STAGES][NCOMP];
   logic [QUO_W-1:0]  prv_quo [DIV_STAGES][NCOMP];
   logic              nbit    [DIV_STAGES][NCOMP];
   logic [ROOT_W:0]   acc     [DIV_STAGES][NCOMP];
   logic              ge      [DIV_STAGES][NCOMP];

   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         prv_len[k] = (k == 0) ? len_in : len_ff[k-1];
         for (int c = 0; c < NCOMP; c++) begin
            if (k == 0) begin
               prv_rem[k][c] = ROOT_W'(side_in.mag[c] >> 1);
               prv_quo[k][c] = '0;
               nbit[k][c]    = side_in.mag[c][0];
            end else begin
               prv_rem[k][c] = rem_ff[k-1][c];
               prv_quo[k][c] = quo_ff[k-1][c];
               nbit[k][c]    = 1'b0;
            end
            acc[k][c]    = {prv_rem[k][c], nbit[k][c]};
            ge[k][c]     = (acc[k][c] >= {1'b0, prv_len[k]});
            rem_in[k][c] = ge[k][c] ? ROOT_W'(acc[k][c] - {1'b0, prv_len[k]})
                                    : ROOT_W'(acc[k][c]);
            quo_in[k][c] = {prv_quo[k][c][QUO_W-2:0], ge[k][c]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            len_ff[k]  <= prv_len[k];
            side_ff[k] <= (k == 0) ? side_in : side_ff[k-1];
            for (int c = 0; c < NCOMP; c++) begin
               rem_ff[k][c] <= rem_in[k][c];
               quo_ff[k][c] <= quo_in[k][c];
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
         quo_out[c] = quo_ff[DIV_STAGES-1][c];
      end
   end

   assign side_out = side_ff[DIV_STAGES-1];

endmodule

@@ sv/vec3_normalize_unit.sv @@
// Normalizes a signed Q8.16 3-vector to Q2.16 unit length. One vector is taken
// per clock when not held, and passes through the input register, squaring,
// sum and threshold compare, a 24-stage square root that resolves one root bit
// per stage, a 17-stage divider that yields one quotient bit per stage for all
// three components, and the output register. The whole pipeline moves together
// and holds while a result waits on rsp_tready. A sum of squares at or below
// min_square gives a zero vector with ok low.
// depends on vnorm_pkg, vnorm_sqrt, vnorm_div and vec3_normalize_unit_defines.svh
`include "vec3_normalize_unit_defines.svh"

module vec3_normalize_unit import vnorm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [SUM_W-1:0]      csr_wdata,   // min_square
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,   // x_in, y_in, z_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata,   // nx, ny, nz, zero pad
   output logic                  rsp_tuser    // ok
);

   logic                              adv;
   logic [SUM_W-1:0]                  min_square_ff;
   logic [NSTAGES-1:0]                vld_ff, vld_in;

   logic [NCOMP-1:0][COMP_W-1:0]      comp_ff;
   logic [NCOMP-1:0][MAG_W-1:0]       mag_in;
   logic [NCOMP-1:0]                  neg_in;
   logic [NCOMP-1:0][SQ_W-1:0]        sq_ff, sq_in;
   side_type                          side1_ff, side2_ff, side2_in;
   logic [SUM_W-1:0]                  sum_ff, sum_in;

   logic [ROOT_W-1:0]                 root;
   side_type                          side_sqrt, side_div;
   logic [NCOMP-1:0][QUO_W-1:0]       quo;

   logic [NCOMP-1:0][OUT_W-1:0]       res_in, res_ff;
   logic                              ok_in, ok_ff;
   logic [NCOMP-1:0]                  in_range;

   assign adv        = !vld_ff[NSTAGES-1] || rsp_tready;
   assign req_tready = adv;
   assign vld_in     = adv ? {vld_ff[NSTAGES-2:0], req_tvalid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         min_square_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (csr_we) begin
            min_square_ff <= csr_wdata;
         end
      end
   end

   // magnitude and square
   always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
         neg_in[c] = comp_ff[c][COMP_W-1];
         mag_in[c] = neg_in[c] ? MAG_W'(-comp_ff[c]) : MAG_W'(comp_ff[c]);
         sq_in[c]  = SQ_W'(mag_in[c] * mag_in[c]);
      end
   end

   // sum and threshold
   always_comb begin
      sum_in        = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      side2_in      = side1_ff;
      side2_in.fail = (sum_in <= min_square_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < NCOMP; c++) begin
            comp_ff[c] <= req_tdata[c*COMP_W +: COMP_W];
         end
         sq_ff         <= sq_in;
         side1_ff.mag  <= mag_in;
         side1_ff.neg  <= neg_in;
         side1_ff.fail <= 1'b0;
         sum_ff        <= sum_in;
         side2_ff      <= side2_in;
      end
   end

   vnorm_sqrt u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .sum_in   (sum_ff),
      .side_in  (side2_ff),
      .root_out (root),
      .side_out (side_sqrt)
   );

   vnorm_div u_div (
      .clock    (clock),
      .adv      (adv),
      .len_in   (root),
      .side_in  (side_sqrt),
      .quo_out  (quo),
      .side_out (side_div)
   );

   // saturate, sign and zero on failure
   always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
         if (side_div.fail) begin
            res_in[c] = '0;
         end else if (side_div.neg[c]) begin
            res_in[c] = -{1'b0, (quo[c] > UNIT) ? UNIT : quo[c]};
         end else begin
            res_in[c] = {1'b0, (quo[c] > UNIT) ? UNIT : quo[c]};
         end
      end
      ok_in = !side_div.fail;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         ok_ff  <= ok_in;
      end
   end

   assign rsp_tvalid = vld_ff[NSTAGES-1];
   assign rsp_tdata  = {(OUT_DATA_W - NCOMP*OUT_W)'(0), res_ff};
   assign rsp_tuser  = ok_ff;

   always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
         in_range[c] = (res_ff[c][OUT_W-1 -: 2] == 2'b00) ||
                       (res_ff[c][OUT_W-1 -: 2] == 2'b11) ||
                       (res_ff[c] == {1'b0, UNIT});
      end
   end

   `VNORM_ASSERT(a_fail_gives_zero, rsp_tvalid && !rsp_tuser, res_ff == '0)
   `VNORM_ASSERT(a_result_in_range, rsp_tvalid && rsp_tuser, in_range == '1)
   `VNORM_ASSERT_NEXT(a_stall_holds_pipe, !adv, vld_ff == $past(vld_ff))

endmodule
